// ===== hw/rtl/cea_pkg.sv =====
// Shared constants and types for the Coulomb and exchange accumulator.
`timescale 1ns / 1ps

package cea_pkg;

  localparam int NumBasisDef = 8;
  localparam int IdxWidth    = 3;
  localparam int ValWidth    = 32;
  localparam int AccWidth    = 48;
  localparam int ProdWidth   = 40;
  localparam int FracBits    = 24;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ACCUM = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_RD   = 5'b01000,
    S_CLR  = 5'b10000
  } state_e;

endpackage

// ===== hw/rtl/cea_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module cea_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cea_mac.sv =====
// Two parallel multipliers on Q8.24 operands, products truncated to Q16.24, and saturating 48-bit accumulation.
`timescale 1ns / 1ps

module cea_mac
  import cea_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [ValWidth-1:0] dens_j_i,
  input  logic signed [ValWidth-1:0] dens_k_i,
  input  logic signed [ValWidth-1:0] value_i,
  input  logic signed [AccWidth-1:0] acc_j_i,
  input  logic signed [AccWidth-1:0] acc_k_i,
  output logic signed [AccWidth-1:0] sum_j_o,
  output logic signed [AccWidth-1:0] sum_k_o
);

  logic signed [2*ValWidth-1:0] full_j, full_k;
  logic signed [ProdWidth-1:0]  prod_j_q, prod_k_q;
  logic signed [AccWidth-1:0]   acc_j_q, acc_k_q;

  assign full_j = dens_j_i * value_i;
  assign full_k = dens_k_i * value_i;

  // The product is truncated toward minus infinity by dropping fraction bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_j_q <= full_j[2*ValWidth-1:FracBits];
      prod_k_q <= full_k[2*ValWidth-1:FracBits];
      acc_j_q  <= acc_j_i;
      acc_k_q  <= acc_k_i;
    end
  end

  function automatic logic [AccWidth-1:0] sat_add(logic [AccWidth-1:0] acc,
                                                  logic [ProdWidth-1:0] inc);
    logic [AccWidth:0] s;
    s = {acc[AccWidth-1], acc} + {{(AccWidth-ProdWidth+1){inc[ProdWidth-1]}}, inc};
    if (s[AccWidth] != s[AccWidth-1]) begin
      sat_add = s[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    end else begin
      sat_add = s[AccWidth-1:0];
    end
  endfunction

  assign sum_j_o = sat_add(acc_j_q, prod_j_q);
  assign sum_k_o = sat_add(acc_k_q, prod_k_q);

endmodule

// ===== hw/rtl/coulomb_exchange_accumulate.sv =====
// Top level of the Coulomb and exchange accumulator for a two-electron Fock build.
`timescale 1ns / 1ps

// A request is taken at a rising clock edge where start is high and busy is low.
// The func_i field selects one of four requests. A density load writes D(a,b)
// and busy stays low. An integral request reads D(d,c), D(b,c), J(a,b) and
// K(a,d), multiplies in state S_MUL and writes both accumulators back in
// state S_ACC, with busy high in both states; the read-modify-write through
// the accumulator memories sets this sequence. A read request reads J(a,b)
// and K(a,b) and is busy in state S_RD; its result appears in the cycle after
// S_RD with done_o high for exactly one cycle, and the next request may be
// taken in that same cycle. The receiver cannot stall, so results are never
// held. A clear request sweeps all NumBasis*NumBasis entries of both
// accumulator memories, one entry per cycle, with busy high. After reset the
// same sweep runs once before the first request is taken. Density entries are
// not cleared; using one that was never loaded gives an undefined sum. Loads
// and integrals whose indices reach NumBasis write nothing, and a read of
// such an element returns zero with row and column echoed.

module coulomb_exchange_accumulate
  import cea_pkg::*;
#(
  parameter int NumBasis = NumBasisDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 func_i,
  input  logic [IdxWidth-1:0]        idx_a_i,
  input  logic [IdxWidth-1:0]        idx_b_i,
  input  logic [IdxWidth-1:0]        idx_c_i,
  input  logic [IdxWidth-1:0]        idx_d_i,
  input  logic signed [ValWidth-1:0] value_i,
  output logic                       done_o,
  output logic [IdxWidth-1:0]        row_o,
  output logic [IdxWidth-1:0]        col_o,
  output logic signed [ValWidth-1:0] jk_value_o
);

  localparam int Cells = NumBasis * NumBasis;
  localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Cells - 1);

  function automatic logic in_rng(logic [IdxWidth-1:0] x);
    in_rng = int'(x) < NumBasis;
  endfunction

  function automatic logic [AddrW-1:0] elem_addr(logic [IdxWidth-1:0] r,
                                                 logic [IdxWidth-1:0] c);
    elem_addr = AddrW'(int'(r) * NumBasis + int'(c));
  endfunction

  state_e state_q, state_d;
  func_e  func;
  logic   accept;

  logic [AddrW-1:0]          clr_cnt_q, clr_cnt_d;
  logic [AddrW-1:0]          addr_j_q, addr_k_q;
  logic [IdxWidth-1:0]       row_q, col_q;
  logic                      ok_q;
  logic signed [ValWidth-1:0] value_q;

  logic                      done_q;
  logic [IdxWidth-1:0]       row_out_q, col_out_q;
  logic signed [ValWidth-1:0] jk_q;

  logic                      ab_ok, all_ok;
  logic [AddrW-1:0]          addr_ab;
  logic                      dens_we, acc_re, acc_we;
  logic [AddrW-1:0]          acc_k_raddr, acc_j_waddr, acc_k_waddr;
  logic signed [ValWidth-1:0] dens_j, dens_k;
  logic signed [AccWidth-1:0] acc_j, acc_k, sum_j, sum_k, wr_j, wr_k;
  logic [AccWidth:0]         diff;
  logic signed [ValWidth-1:0] jk_d;

  assign func    = func_e'(func_i);
  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign ab_ok   = in_rng(idx_a_i) && in_rng(idx_b_i);
  assign all_ok  = ab_ok && in_rng(idx_c_i) && in_rng(idx_d_i);
  assign addr_ab = elem_addr(idx_a_i, idx_b_i);

  // Density is kept twice so that both density operands come out in one read.
  assign dens_we = accept && (func == FUNC_LOAD) && ab_ok;

  cea_ram #(.Width(ValWidth), .Depth(Cells)) u_dens_j (
    .clk_i  (clk_i),
    .we_i   (dens_we),
    .waddr_i(addr_ab),
    .wdata_i(value_i),
    .re_i   (accept),
    .raddr_i(elem_addr(idx_d_i, idx_c_i)),
    .rdata_o(dens_j)
  );

  cea_ram #(.Width(ValWidth), .Depth(Cells)) u_dens_k (
    .clk_i  (clk_i),
    .we_i   (dens_we),
    .waddr_i(addr_ab),
    .wdata_i(value_i),
    .re_i   (accept),
    .raddr_i(elem_addr(idx_b_i, idx_c_i)),
    .rdata_o(dens_k)
  );

  // The exchange read address is K(a,d) for an integral and K(a,b) for a read.
  assign acc_re      = accept;
  assign acc_k_raddr = (func == FUNC_ACCUM) ? elem_addr(idx_a_i, idx_d_i) : addr_ab;
  assign acc_we      = ((state_q == S_ACC) && ok_q) || (state_q == S_CLR);
  assign acc_j_waddr = (state_q == S_CLR) ? clr_cnt_q : addr_j_q;
  assign acc_k_waddr = (state_q == S_CLR) ? clr_cnt_q : addr_k_q;
  assign wr_j        = (state_q == S_CLR) ? '0 : sum_j;
  assign wr_k        = (state_q == S_CLR) ? '0 : sum_k;

  cea_ram #(.Width(AccWidth), .Depth(Cells)) u_acc_j (
    .clk_i  (clk_i),
    .we_i   (acc_we),
    .waddr_i(acc_j_waddr),
    .wdata_i(wr_j),
    .re_i   (acc_re),
    .raddr_i(addr_ab),
    .rdata_o(acc_j)
  );

  cea_ram #(.Width(AccWidth), .Depth(Cells)) u_acc_k (
    .clk_i  (clk_i),
    .we_i   (acc_we),
    .waddr_i(acc_k_waddr),
    .wdata_i(wr_k),
    .re_i   (acc_re),
    .raddr_i(acc_k_raddr),
    .rdata_o(acc_k)
  );

  cea_mac u_mac (
    .clk_i   (clk_i),
    .en_i    (state_q == S_MUL),
    .dens_j_i(dens_j),
    .dens_k_i(dens_k),
    .value_i (value_q),
    .acc_j_i (acc_j),
    .acc_k_i (acc_k),
    .sum_j_o (sum_j),
    .sum_k_o (sum_k)
  );

  // Combined element J - K/2, with K halved toward minus infinity, clamped to 32 bits.
  always_comb begin
    diff = {acc_j[AccWidth-1], acc_j} - {{2{acc_k[AccWidth-1]}}, acc_k[AccWidth-1:1]};
    if (!ok_q) begin
      jk_d = '0;
    end else if (diff[AccWidth] && !(&diff[AccWidth-1:ValWidth-1])) begin
      jk_d = {1'b1, {(ValWidth-1){1'b0}}};
    end else if (!diff[AccWidth] && (|diff[AccWidth-1:ValWidth-1])) begin
      jk_d = {1'b0, {(ValWidth-1){1'b1}}};
    end else begin
      jk_d = diff[ValWidth-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_LOAD:  state_d = S_IDLE;
            FUNC_ACCUM: state_d = S_MUL;
            FUNC_READ:  state_d = S_RD;
            FUNC_CLEAR: begin
              state_d   = S_CLR;
              clr_cnt_d = '0;
            end
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = S_IDLE;
      S_RD:   state_d = S_IDLE;
      S_CLR: begin
        if (clr_cnt_q == LastAddr) begin
          state_d = S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AddrW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= (state_q == S_RD);
    end
  end

  // Request fields are held for the cycles that follow the memory reads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_j_q <= addr_ab;
      addr_k_q <= elem_addr(idx_a_i, idx_d_i);
      row_q    <= idx_a_i;
      col_q    <= idx_b_i;
      value_q  <= value_i;
      ok_q     <= (func == FUNC_ACCUM) ? all_ok : ab_ok;
    end
    if (state_q == S_RD) begin
      row_out_q <= row_q;
      col_out_q <= col_q;
      jk_q      <= jk_d;
    end
  end

  assign done_o     = done_q;
  assign row_o      = row_out_q;
  assign col_o      = col_out_q;
  assign jk_value_o = jk_q;

endmodule

// ===== tb/jk_build_checker.sv =====
// Watches the request and result ports, predicts every read and compares it.
`timescale 1ns / 1ps

module jk_build_checker
  import cea_pkg::*;
#(
  parameter int NumBasis = NumBasisDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [1:0]                 func_i,
  input  logic [IdxWidth-1:0]        idx_a_i,
  input  logic [IdxWidth-1:0]        idx_b_i,
  input  logic [IdxWidth-1:0]        idx_c_i,
  input  logic [IdxWidth-1:0]        idx_d_i,
  input  logic signed [ValWidth-1:0] value_i,
  input  logic                       done_i,
  input  logic [IdxWidth-1:0]        row_i,
  input  logic [IdxWidth-1:0]        col_i,
  input  logic signed [ValWidth-1:0] jk_value_i,
  output int                         mismatches_o,
  output int                         reads_awaiting_o
);

  localparam int     Slots = NumBasis * NumBasis;
  localparam int     DueDepth = 4;
  localparam longint AccMax = (longint'(1) <<< (AccWidth - 1)) - 1;
  localparam longint AccMin = -AccMax - 1;
  localparam longint JkMax = 64'sh7FFF_FFFF;
  localparam longint JkMin = -JkMax - 1;

  typedef struct packed {
    logic [IdxWidth-1:0]        row;
    logic [IdxWidth-1:0]        col;
    logic signed [ValWidth-1:0] jk;
  } jk_read_t;

  logic signed [ValWidth-1:0] density_q  [Slots];
  logic signed [AccWidth-1:0] coulomb_q  [Slots];
  logic signed [AccWidth-1:0] exchange_q [Slots];
  // Predicted reads wait in a small ring until their results come out.
  jk_read_t                   jk_reads_due [DueDepth];
  int                         due_head = 0;
  int                         due_count = 0;
  int                         mismatches = 0;

  function automatic bit fits(input logic [IdxWidth-1:0] idx);
    return int'(idx) < NumBasis;
  endfunction

  function automatic int slot(input logic [IdxWidth-1:0] r, input logic [IdxWidth-1:0] c);
    return int'(r) * NumBasis + int'(c);
  endfunction

  // Exact Q16.48 product, floored back to Q16.24.
  function automatic longint q24_product(input logic signed [ValWidth-1:0] x,
                                         input logic signed [ValWidth-1:0] y);
    return (longint'(x) * longint'(y)) >>> FracBits;
  endfunction

  function automatic logic signed [AccWidth-1:0] add_sat48(
      input logic signed [AccWidth-1:0] acc, input longint inc);
    longint sum;
    sum = longint'(acc) + inc;
    if (sum > AccMax) sum = AccMax;
    if (sum < AccMin) sum = AccMin;
    return AccWidth'(sum);
  endfunction

  function automatic jk_read_t predict_jk_read(input logic [IdxWidth-1:0] r,
                                               input logic [IdxWidth-1:0] c);
    jk_read_t res;
    longint   diff;
    res.row = r;
    res.col = c;
    res.jk  = '0;
    if (fits(r) && fits(c)) begin
      diff = longint'(coulomb_q[slot(r, c)]) - (longint'(exchange_q[slot(r, c)]) >>> 1);
      if (diff > JkMax) diff = JkMax;
      if (diff < JkMin) diff = JkMin;
      res.jk = ValWidth'(diff);
    end
    return res;
  endfunction

  function automatic void check_field(input string field, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    jk_read_t want;
    if (!rst_ni) begin
      foreach (coulomb_q[i]) begin
        coulomb_q[i]  = '0;
        exchange_q[i] = '0;
      end
      due_head  = 0;
      due_count = 0;
    end else begin
      // A result can never come out on the edge that takes its read, so the
      // result side is handled before the request side.
      if (done_i) begin
        if (due_count == 0) begin
          $error("unrequested result: row %0d col %0d jk_value %0d",
                 row_i, col_i, jk_value_i);
          mismatches++;
        end else begin
          want      = jk_reads_due[due_head];
          due_head  = (due_head + 1) % DueDepth;
          due_count = due_count - 1;
          check_field("row", want.row, row_i);
          check_field("col", want.col, col_i);
          check_field("jk_value", longint'($signed(want.jk)), longint'(jk_value_i));
        end
      end
      if (start_i && !busy_i) begin
        case (func_e'(func_i))
          FUNC_LOAD: begin
            if (fits(idx_a_i) && fits(idx_b_i)) density_q[slot(idx_a_i, idx_b_i)] = value_i;
          end
          FUNC_ACCUM: begin
            if (fits(idx_a_i) && fits(idx_b_i) && fits(idx_c_i) && fits(idx_d_i)) begin
              coulomb_q[slot(idx_a_i, idx_b_i)] = add_sat48(coulomb_q[slot(idx_a_i, idx_b_i)],
                  q24_product(density_q[slot(idx_d_i, idx_c_i)], value_i));
              exchange_q[slot(idx_a_i, idx_d_i)] = add_sat48(exchange_q[slot(idx_a_i, idx_d_i)],
                  q24_product(density_q[slot(idx_b_i, idx_c_i)], value_i));
            end
          end
          FUNC_READ: begin
            if (due_count == DueDepth) begin
              $error("read backlog overflow: row %0d col %0d", idx_a_i, idx_b_i);
              mismatches++;
            end else begin
              jk_reads_due[(due_head + due_count) % DueDepth] =
                  predict_jk_read(idx_a_i, idx_b_i);
              due_count = due_count + 1;
            end
          end
          default: begin
            foreach (coulomb_q[i]) begin
              coulomb_q[i]  = '0;
              exchange_q[i] = '0;
            end
          end
        endcase
      end
    end
    mismatches_o     <= mismatches;
    reads_awaiting_o <= due_count;
  end

endmodule

// ===== tb/tb.sv =====
// Top of the Coulomb and exchange accumulator testbench: stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import cea_pkg::*;

  // The limit below sits well above the slowest legal run: about 1250 requests,
  // each behind a sender gap bounded by MaxGap plus its own busy time, a few
  // clear sweeps and the sweep after reset.
  localparam int CycleLimit   = 300000;
  localparam int DrainCycles  = 8;
  localparam int MaxGap       = 40;
  localparam int SatRunLength = 520;
  localparam int PhaseItems   = 235;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 func_i = FUNC_LOAD;
  logic [IdxWidth-1:0]        idx_a_i = '0;
  logic [IdxWidth-1:0]        idx_b_i = '0;
  logic [IdxWidth-1:0]        idx_c_i = '0;
  logic [IdxWidth-1:0]        idx_d_i = '0;
  logic signed [ValWidth-1:0] value_i = '0;
  logic                       done_o;
  logic [IdxWidth-1:0]        row_o;
  logic [IdxWidth-1:0]        col_o;
  logic signed [ValWidth-1:0] jk_value_o;
  int                         mismatches;
  int                         reads_awaiting;

  // Stimulus bookkeeping: which density entries hold a loaded value, how often
  // the sender idles in the current phase, and how many requests went out.
  bit [63:0] density_loaded = '0;
  int        idle_pct = 0;
  int        requests_sent = 0;

  coulomb_exchange_accumulate dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (func_i),
    .idx_a_i    (idx_a_i),
    .idx_b_i    (idx_b_i),
    .idx_c_i    (idx_c_i),
    .idx_d_i    (idx_d_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .row_o      (row_o),
    .col_o      (col_o),
    .jk_value_o (jk_value_o)
  );

  jk_build_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .func_i           (func_i),
    .idx_a_i          (idx_a_i),
    .idx_b_i          (idx_b_i),
    .idx_c_i          (idx_c_i),
    .idx_d_i          (idx_d_i),
    .value_i          (value_i),
    .done_i           (done_o),
    .row_i            (row_o),
    .col_i            (col_o),
    .jk_value_i       (jk_value_o),
    .mismatches_o     (mismatches),
    .reads_awaiting_o (reads_awaiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Values come in three flavors. Random words shifted down arithmetically give
  // moderate magnitudes at many scales, which keep reads out of saturation.
  // Raw random words give large products that saturate the 32-bit read.
  // The extremes hit the corners of the multiplier and of the floor rounding.
  function automatic logic signed [ValWidth-1:0] pick_value();
    logic signed [ValWidth-1:0] raw;
    int unsigned                sel;
    raw = $urandom;
    sel = $urandom_range(99);
    if (sel < 50) return raw >>> $urandom_range(30, 5);
    if (sel < 85) return raw;
    case ($urandom_range(3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  // Presents one request and holds it until the block takes it. Each field is
  // assigned once per time step. When the sender idles afterwards, start drops
  // at the accepting edge; otherwise it stays high and the next request's
  // fields replace these at that same edge.
  task automatic issue(input func_e f, input logic [IdxWidth-1:0] a,
                       input logic [IdxWidth-1:0] b, input logic [IdxWidth-1:0] c,
                       input logic [IdxWidth-1:0] d, input logic signed [ValWidth-1:0] v);
    int gap;
    gap = 0;
    func_i  <= f;
    idx_a_i <= a;
    idx_b_i <= b;
    idx_c_i <= c;
    idx_d_i <= d;
    value_i <= v;
    start   <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests_sent++;
    while (gap < MaxGap && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The unused index fields carry random noise so that their bits toggle
  // under every request type.
  task automatic load_density(input logic [IdxWidth-1:0] r, input logic [IdxWidth-1:0] c,
                              input logic signed [ValWidth-1:0] v);
    issue(FUNC_LOAD, r, c, IdxWidth'($urandom), IdxWidth'($urandom), v);
    density_loaded[{r, c}] = 1'b1;
  endtask

  task automatic read_element(input logic [IdxWidth-1:0] r, input logic [IdxWidth-1:0] c);
    issue(FUNC_READ, r, c, IdxWidth'($urandom), IdxWidth'($urandom), $urandom);
  endtask

  task automatic clear_accumulators();
    issue(FUNC_CLEAR, IdxWidth'($urandom), IdxWidth'($urandom), IdxWidth'($urandom),
          IdxWidth'($urandom), $urandom);
  endtask

  // An integral must never touch a density entry that was never loaded, since
  // the block leaves those undefined. Missing entries get loaded first, which
  // makes the integral the tail of a well-formed load-then-use sequence.
  task automatic send_integral(input logic [IdxWidth-1:0] a, input logic [IdxWidth-1:0] b,
                               input logic [IdxWidth-1:0] c, input logic [IdxWidth-1:0] d,
                               input logic signed [ValWidth-1:0] v);
    if (!density_loaded[{d, c}]) load_density(d, c, pick_value());
    if (!density_loaded[{b, c}]) load_density(b, c, pick_value());
    issue(FUNC_ACCUM, a, b, c, d, v);
  endtask

  // Watchdog: a hung handshake or a result that never comes ends here.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [IdxWidth-1:0] ia, ib, ic, id;
    int unsigned         sel;
    int                  phase_end;
    int                  idle_plan [3];

    // The receiver can never stall here, so the phase where only the receiver
    // would stall is the same as the one with no idling and is not repeated.
    idle_plan = '{0, 85, 10};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The first request waits out the clearing sweep that the
    // block runs after reset. A read before any integral must return zero.
    read_element(3'd0, 3'd0);
    load_density(3'd0, 3'd0, 32'sh7FFF_FFFF);
    load_density(3'd7, 3'd7, 32'sh8000_0000);
    load_density(3'd0, 3'd7, 32'sh0000_0001);
    load_density(3'd7, 3'd0, -32'sd1);
    // Largest positive-by-positive product into the same J and K element.
    issue(FUNC_ACCUM, 3'd0, 3'd0, 3'd0, 3'd0, 32'sh7FFF_FFFF);
    read_element(3'd0, 3'd0);
    // Most negative times most negative: the largest product there is, so the
    // read of J - K/2 saturates at the top of the 32-bit range.
    issue(FUNC_ACCUM, 3'd7, 3'd7, 3'd7, 3'd7, 32'sh8000_0000);
    read_element(3'd7, 3'd7);
    // A large negative product into J(7,0) drives the read to the bottom of
    // the range, while a tiny product lands in K(7,7).
    issue(FUNC_ACCUM, 3'd7, 3'd0, 3'd7, 3'd7, 32'sh7FFF_FFFF);
    read_element(3'd7, 3'd0);
    // One LSB times minus one floors to minus one in both accumulators, and
    // halving minus one floors to minus one again, so the read gives zero.
    issue(FUNC_ACCUM, 3'd2, 3'd0, 3'd7, 3'd0, -32'sd1);
    read_element(3'd2, 3'd0);
    // A zero integral leaves the element at zero.
    issue(FUNC_ACCUM, 3'd1, 3'd7, 3'd0, 3'd7, 32'sh0000_0000);
    read_element(3'd1, 3'd7);
    // A clear wipes both accumulators but keeps the density store.
    clear_accumulators();
    read_element(3'd7, 3'd7);
    read_element(3'd0, 3'd0);

    // Saturation run. With D(d,c) at the negative extreme and D(b,c) at the
    // positive one, each integral of the most negative value adds 2^38 to
    // J(a,b) and about -2^38 to K(a,d); some 512 of them pin J at the top of
    // the 48-bit range and K at its bottom. Indices b and d differ.
    ia = IdxWidth'($urandom);
    ib = IdxWidth'($urandom);
    ic = IdxWidth'($urandom);
    id = ib + 3'd1 + 3'($urandom_range(6));
    load_density(id, ic, 32'sh8000_0000);
    load_density(ib, ic, 32'sh7FFF_FFFF);
    repeat (SatRunLength) issue(FUNC_ACCUM, ia, ib, ic, id, 32'sh8000_0000);
    read_element(ia, ib);
    read_element(ia, id);
    clear_accumulators();

    // Random part, one phase per sender idling rate. Most traffic is integral
    // sequences, often followed by a read of an element they touched; the rest
    // is stray loads, reads of arbitrary elements and the odd clear.
    foreach (idle_plan[p]) begin
      idle_pct  = idle_plan[p];
      phase_end = requests_sent + PhaseItems;
      while (requests_sent < phase_end) begin
        sel = $urandom_range(99);
        ia  = IdxWidth'($urandom);
        ib  = IdxWidth'($urandom);
        ic  = IdxWidth'($urandom);
        id  = IdxWidth'($urandom);
        if (sel < 55) begin
          send_integral(ia, ib, ic, id, pick_value());
          if ($urandom_range(2) == 0) read_element(ia, $urandom_range(1) ? ib : id);
        end else if (sel < 70) begin
          load_density(ia, ib, pick_value());
        end else if (sel < 95) begin
          read_element(ia, ib);
        end else if (sel < 98) begin
          clear_accumulators();
        end else begin
          // A burst of back-to-back integrals onto one element.
          repeat ($urandom_range(12, 4)) send_integral(ia, ib, ic, id, pick_value());
          read_element(ia, ib);
        end
      end
    end

    if (start) start <= 1'b0;

    // Let the last reads come back, then give the block a few more cycles in
    // which any stray result would still be caught.
    @(posedge clk_i);
    while (reads_awaiting != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && reads_awaiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
